@@ rtl/core/tsc_pkg.sv @@
// shared types, constants and helpers of the template sad classifier
package tsc_pkg;

	localparam int NUM_TEMPL = 15;
	localparam int TEMPL_DIM = 16;
	localparam int PATCH_DIM = 32;

	localparam int TCOORD_W = $clog2(TEMPL_DIM);
	localparam int PCOORD_W = $clog2(PATCH_DIM);
	localparam int TADDR_W  = 2 * TCOORD_W;
	localparam int PADDR_W  = 2 * PCOORD_W;
	localparam int PIX_W    = 24;
	localparam int PSAD_W   = 10;
	localparam int SCORE_W  = 18;
	localparam int TID_W    = 4;

	localparam logic [1:0] ACT_TPIX     = 2'd0;
	localparam logic [1:0] ACT_PPIX     = 2'd1;
	localparam logic [1:0] ACT_CLASSIFY = 2'd2;

	localparam logic [2:0] CFG_TW = 3'd0;
	localparam logic [2:0] CFG_TH = 3'd1;
	localparam logic [2:0] CFG_PW = 3'd2;
	localparam logic [2:0] CFG_PH = 3'd3;
	localparam logic [2:0] CFG_NT = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_MERGE
	} state_t;

	typedef struct packed {
		logic valid;
		logic first_pix;
		logic last_pix;
		logic first_off;
	} lane_ctl_t;

	function automatic logic [4:0] clamp_tdim(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (v == 5'd0) r = 5'd1;
		else if (v > 5'(TEMPL_DIM)) r = 5'(TEMPL_DIM);
		return r;
	endfunction

	function automatic logic [5:0] clamp_pdim(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		if (v == 6'd0) r = 6'd1;
		else if (v > 6'(PATCH_DIM)) r = 6'(PATCH_DIM);
		return r;
	endfunction

	function automatic logic [3:0] clamp_ntempl(input logic [3:0] v);
		logic [3:0] r;
		r = v;
		if (v == 4'd0) r = 4'd1;
		else if ({1'b0, v} > 5'(NUM_TEMPL)) r = 4'(NUM_TEMPL);
		return r;
	endfunction

endpackage

@@ rtl/core/tsc_ram.sv @@
// generic simple dual port ram with registered read
module tsc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

@@ rtl/core/tsc_lane.sv @@
// one template lane: template store, per-offset sad accumulation, running minimum
module tsc_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [tsc_pkg::TADDR_W-1:0] wr_addr,
	input  logic [tsc_pkg::PIX_W-1:0]   wr_data,
	input  logic [tsc_pkg::TADDR_W-1:0] rd_addr,
	input  tsc_pkg::lane_ctl_t          ctl_s1,
	input  logic [tsc_pkg::PIX_W-1:0]   p_pix_s1,
	output logic [tsc_pkg::SCORE_W-1:0] lane_best
);
	import tsc_pkg::*;

	logic [PIX_W-1:0]   t_pix_s1;
	logic [8:0]         d0, d1, d2;
	logic [PSAD_W-1:0]  psad_s2;
	lane_ctl_t          ctl_s2;
	logic [SCORE_W-1:0] acc_q, acc_next;
	logic [SCORE_W-1:0] off_sum_s3;
	logic               off_v_s3, off_first_s3;
	logic [SCORE_W-1:0] min_q;

	tsc_ram #(.WIDTH(PIX_W), .DEPTH(TEMPL_DIM * TEMPL_DIM)) u_tram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (t_pix_s1)
	);

	function automatic logic [8:0] absd(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
	endfunction

	assign d0 = absd(t_pix_s1[7:0],   p_pix_s1[7:0]);
	assign d1 = absd(t_pix_s1[15:8],  p_pix_s1[15:8]);
	assign d2 = absd(t_pix_s1[23:16], p_pix_s1[23:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		psad_s2 <= PSAD_W'(d0) + PSAD_W'(d1) + PSAD_W'(d2);
	end

	assign acc_next = ctl_s2.first_pix ? SCORE_W'(psad_s2) : acc_q + SCORE_W'(psad_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_v_s3 <= 1'b0;
		end else begin
			off_v_s3 <= ctl_s2.valid && ctl_s2.last_pix;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q        <= acc_next;
			off_sum_s3   <= acc_next;
			off_first_s3 <= ctl_s2.first_off;
		end
		// earlier offset wins ties
		if (off_v_s3 && (off_first_s3 || off_sum_s3 < min_q)) begin
			min_q <= off_sum_s3;
		end
	end

	assign lane_best = min_q;
endmodule

@@ rtl/core/template_sad_classifier_top.sv @@
// top level of the template sad classifier: sequencer, patch store, lanes and merge
// operation: pixel writes go straight to the stores; a classify scans all
//   (ph-th+1)*(pw-tw+1) offsets of th*tw pixels each, drains the lane pipeline, then
//   merges the nt lane minima (nt templates in use) and loads the output register
// throughput: one pixel write per cycle while idle; one classify at a time, set by the single
//   patch ram read port shared by all template lanes (one pixel position per cycle)
// a size error result is registered and ready in the cycle after the classify transfer
// reset: asynchronous active low; clears control state and restores register defaults,
//   pixel stores are not cleared and hold garbage until written
module template_sad_classifier_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [3:0]                  templ_index,
	input  logic [4:0]                  pix_x,
	input  logic [4:0]                  pix_y,
	input  logic [7:0]                  chan0,
	input  logic [7:0]                  chan1,
	input  logic [7:0]                  chan2,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [3:0]                  class_id,
	output logic [tsc_pkg::SCORE_W-1:0] best_score,
	output logic                        size_error,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [5:0]                  cfg_data
);
	import tsc_pkg::*;

	// configuration registers
	logic [4:0] templ_width_q, templ_height_q;
	logic [5:0] patch_width_q, patch_height_q;
	logic [3:0] templates_in_use_q;

	// saturated working dimensions
	logic [4:0] tw, th;
	logic [5:0] pw, ph;
	logic [3:0] nt;
	logic       dim_err;

	// search bounds latched at classify start
	logic [TCOORD_W-1:0] tw_m1_q, th_m1_q;
	logic [PCOORD_W-1:0] dx_max_q, dy_max_q;
	logic [TID_W-1:0]    nt_m1_q;

	// scan counters
	logic [TCOORD_W-1:0] sx_q, sy_q;
	logic [PCOORD_W-1:0] dx_q, dy_q;
	logic [1:0]          drain_q;
	logic [TID_W-1:0]    merge_idx_q;
	logic [SCORE_W-1:0]  best_q;
	logic [TID_W-1:0]    best_id_q;

	state_t state_q, state_d;

	logic in_xfer, out_xfer, start, start_err;
	logic last_sx, last_sy, last_dx, last_dy, last_issue;
	logic issue, drain_done, merge_last;

	lane_ctl_t ctl_issue, ctl_s1;
	logic [PCOORD_W-1:0] px, py;
	logic [PIX_W-1:0]    p_pix_s1;
	logic [PIX_W-1:0]    pix_in;

	logic [SCORE_W-1:0] lane_min [NUM_TEMPL];
	logic [SCORE_W-1:0] cand;
	logic               take;
	logic [SCORE_W-1:0] merged_score;
	logic [TID_W-1:0]   merged_id;

	// output register
	logic               out_valid_q;
	logic [TID_W-1:0]   class_id_q;
	logic [SCORE_W-1:0] best_score_q;
	logic               size_error_q;

	assign pix_in   = {chan2, chan1, chan0};
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;

	assign tw = clamp_tdim(templ_width_q);
	assign th = clamp_tdim(templ_height_q);
	assign pw = clamp_pdim(patch_width_q);
	assign ph = clamp_pdim(patch_height_q);
	assign nt = clamp_ntempl(templates_in_use_q);
	assign dim_err = ({1'b0, tw} > pw) || ({1'b0, th} > ph);

	assign start     = in_xfer && action == ACT_CLASSIFY && !dim_err;
	assign start_err = in_xfer && action == ACT_CLASSIFY && dim_err;

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			templ_width_q      <= 5'd16;
			templ_height_q     <= 5'd16;
			patch_width_q      <= 6'd30;
			patch_height_q     <= 6'd30;
			templates_in_use_q <= 4'd15;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TW:  templ_width_q      <= cfg_data[4:0];
				CFG_TH:  templ_height_q     <= cfg_data[4:0];
				CFG_PW:  patch_width_q      <= cfg_data;
				CFG_PH:  patch_height_q     <= cfg_data;
				CFG_NT:  templates_in_use_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// end-of-range flags for the row-major offset and pixel scan
	assign last_sx    = sx_q == tw_m1_q;
	assign last_sy    = sy_q == th_m1_q;
	assign last_dx    = dx_q == dx_max_q;
	assign last_dy    = dy_q == dy_max_q;
	assign last_issue = last_sx && last_sy && last_dx && last_dy;
	assign drain_done = drain_q == 2'd3;
	assign merge_last = merge_idx_q == nt_m1_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_RUN;
			ST_RUN:   if (last_issue) state_d = ST_DRAIN;
			ST_DRAIN: if (drain_done) state_d = ST_MERGE;
			ST_MERGE: if (merge_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs; a classify waits while an earlier result is still unread
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = !(out_valid_q && action == ACT_CLASSIFY);
			ST_RUN:   issue = 1'b1;
			ST_DRAIN: ;
			ST_MERGE: ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan counters and bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q        <= '0;
			sy_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			drain_q     <= '0;
			merge_idx_q <= '0;
			tw_m1_q     <= '0;
			th_m1_q     <= '0;
			dx_max_q    <= '0;
			dy_max_q    <= '0;
			nt_m1_q     <= '0;
		end else begin
			if (start) begin
				sx_q        <= '0;
				sy_q        <= '0;
				dx_q        <= '0;
				dy_q        <= '0;
				drain_q     <= '0;
				merge_idx_q <= '0;
				tw_m1_q     <= TCOORD_W'(tw - 5'd1);
				th_m1_q     <= TCOORD_W'(th - 5'd1);
				dx_max_q    <= PCOORD_W'(pw - {1'b0, tw});
				dy_max_q    <= PCOORD_W'(ph - {1'b0, th});
				nt_m1_q     <= nt - 4'd1;
			end else if (issue) begin
				if (!last_sx) begin
					sx_q <= sx_q + 1'b1;
				end else begin
					sx_q <= '0;
					if (!last_sy) begin
						sy_q <= sy_q + 1'b1;
					end else begin
						sy_q <= '0;
						if (!last_dx) begin
							dx_q <= dx_q + 1'b1;
						end else begin
							dx_q <= '0;
							dy_q <= dy_q + 1'b1;
						end
					end
				end
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + 1'b1;
			end
			if (state_q == ST_MERGE) begin
				merge_idx_q <= merge_idx_q + 1'b1;
			end
		end
	end

	// control that rides alongside the ram read data
	assign ctl_issue.valid     = issue;
	assign ctl_issue.first_pix = sx_q == '0 && sy_q == '0;
	assign ctl_issue.last_pix  = last_sx && last_sy;
	assign ctl_issue.first_off = dx_q == '0 && dy_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_issue;
		end
	end

	// patch position of the current template pixel
	assign px = PCOORD_W'(sx_q) + dx_q;
	assign py = PCOORD_W'(sy_q) + dy_q;

	tsc_ram #(.WIDTH(PIX_W), .DEPTH(PATCH_DIM * PATCH_DIM)) u_pram (
		.clk     (clk),
		.wr_en   (in_xfer && action == ACT_PPIX),
		.wr_addr ({pix_y, pix_x}),
		.wr_data (pix_in),
		.rd_addr ({py, px}),
		.rd_data (p_pix_s1)
	);

	// one lane per template, all fed the same patch pixel
	for (genvar g = 0; g < NUM_TEMPL; g++) begin : g_lane
		tsc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (in_xfer && action == ACT_TPIX && templ_index == TID_W'(g)
			            && pix_x < 5'(TEMPL_DIM) && pix_y < 5'(TEMPL_DIM)),
			.wr_addr   ({pix_y[TCOORD_W-1:0], pix_x[TCOORD_W-1:0]}),
			.wr_data   (pix_in),
			.rd_addr   ({sy_q, sx_q}),
			.ctl_s1    (ctl_s1),
			.p_pix_s1  (p_pix_s1),
			.lane_best (lane_min[g])
		);
	end

	// merge: walk the lanes in index order, strict compare keeps the lower index on ties
	assign cand         = lane_min[merge_idx_q];
	assign take         = merge_idx_q == '0 || cand < best_q;
	assign merged_score = take ? cand : best_q;
	assign merged_id    = take ? merge_idx_q : best_id_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MERGE) begin
			best_q    <= merged_score;
			best_id_q <= merged_id;
		end
	end

	// result register, loaded at the end of merge or straight away on a size error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (start_err || (state_q == ST_MERGE && merge_last)) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_err) begin
			class_id_q   <= '0;
			best_score_q <= '0;
			size_error_q <= 1'b1;
		end else if (state_q == ST_MERGE && merge_last) begin
			class_id_q   <= merged_id;
			best_score_q <= merged_score;
			size_error_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign class_id   = class_id_q;
	assign best_score = best_score_q;
	assign size_error = size_error_q;
endmodule

@@ test/tb.sv @@
// self-checking testbench of the template sad classifier with a scoreboard class
`timescale 1ns / 1ps

module tb;
	import tsc_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int WATCH_LIMIT = 50000;

	typedef struct {
		logic [3:0]         class_id;
		logic [SCORE_W-1:0] best_score;
		logic               size_error;
	} sad_result_t;

	// predictor of the classifier: own pixel stores, own register copy, queue of results
	class sad_scoreboard;
		logic [23:0] tpix [NUM_TEMPL][TEMPL_DIM][TEMPL_DIM];
		logic [23:0] ppix [PATCH_DIM][PATCH_DIM];
		logic [4:0] r_tw;
		logic [4:0] r_th;
		logic [5:0] r_pw;
		logic [5:0] r_ph;
		logic [3:0] r_nt;
		sad_result_t pending [$];
		int errors;
		int results_seen;
		int classifies;

		function new();
			r_tw = 5'd16;
			r_th = 5'd16;
			r_pw = 6'd30;
			r_ph = 6'd30;
			r_nt = 4'd15;
			errors = 0;
			results_seen = 0;
			classifies = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [5:0] d);
			case (idx)
				CFG_TW: r_tw = d[4:0];
				CFG_TH: r_th = d[4:0];
				CFG_PW: r_pw = d;
				CFG_PH: r_ph = d;
				CFG_NT: r_nt = d[3:0];
				default: ;
			endcase
		endfunction

		function int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		// minimum sad of template t over every fitting offset
		function int unsigned min_sad(int t, int tw, int th, int pw, int ph);
			int unsigned best;
			int unsigned sum;
			logic [23:0] a;
			logic [23:0] b;
			int d;
			best = 0;
			for (int dy = 0; dy + th <= ph; dy++) begin
				for (int dx = 0; dx + tw <= pw; dx++) begin
					sum = 0;
					for (int sy = 0; sy < th; sy++) begin
						for (int sx = 0; sx < tw; sx++) begin
							a = tpix[t][sy][sx];
							b = ppix[sy + dy][sx + dx];
							for (int c = 0; c < 3; c++) begin
								d = int'(a[c*8 +: 8]) - int'(b[c*8 +: 8]);
								sum += (d < 0) ? -d : d;
							end
						end
					end
					if ((dy == 0 && dx == 0) || sum < best) best = sum;
				end
			end
			return best;
		endfunction

		function void note_input(logic [1:0] act, logic [3:0] ti, logic [4:0] x, logic [4:0] y,
				logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
			int unsigned tw, th, pw, ph, nt, s, best, best_id;
			sad_result_t r;
			case (act)
				ACT_TPIX: begin
					if (ti < NUM_TEMPL && x < TEMPL_DIM && y < TEMPL_DIM)
						tpix[ti][y][x] = {c2, c1, c0};
				end
				ACT_PPIX: ppix[y][x] = {c2, c1, c0};
				ACT_CLASSIFY: begin
					classifies++;
					tw = sat(r_tw, 1, TEMPL_DIM);
					th = sat(r_th, 1, TEMPL_DIM);
					pw = sat(r_pw, 1, PATCH_DIM);
					ph = sat(r_ph, 1, PATCH_DIM);
					nt = sat(r_nt, 1, NUM_TEMPL);
					if (tw > pw || th > ph) begin
						r.class_id = 4'd0;
						r.best_score = '0;
						r.size_error = 1'b1;
					end else begin
						best = 0;
						best_id = 0;
						for (int t = 0; t < nt; t++) begin
							s = min_sad(t, tw, th, pw, ph);
							if (t == 0 || s < best) begin
								best = s;
								best_id = t;
							end
						end
						if (best > 262143) best = 262143;
						r.class_id = best_id[3:0];
						r.best_score = best[SCORE_W-1:0];
						r.size_error = 1'b0;
					end
					pending.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [3:0] cid, logic [SCORE_W-1:0] score, logic serr);
			sad_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				$error("unexpected result class_id=%0d best_score=%0d size_error=%0d",
					cid, score, serr);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (cid !== e.class_id) begin
				$error("class_id expected %0d actual %0d", e.class_id, cid);
				errors++;
			end
			if (score !== e.best_score) begin
				$error("best_score expected %0d actual %0d", e.best_score, score);
				errors++;
			end
			if (serr !== e.size_error) begin
				$error("size_error expected %0d actual %0d", e.size_error, serr);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = '0;
	logic [3:0] templ_index = '0;
	logic [4:0] pix_x = '0;
	logic [4:0] pix_y = '0;
	logic [7:0] chan0 = '0;
	logic [7:0] chan1 = '0;
	logic [7:0] chan2 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] class_id;
	logic [SCORE_W-1:0] best_score;
	logic size_error;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;

	sad_scoreboard sb = new();
	bit no_gaps = 1'b0;
	int idle_cycles = 0;
	int sent = 0;

	template_sad_classifier_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .templ_index(templ_index), .pix_x(pix_x), .pix_y(pix_y),
		.chan0(chan0), .chan1(chan1), .chan2(chan2),
		.out_valid(out_valid), .out_ready(out_ready),
		.class_id(class_id), .best_score(best_score), .size_error(size_error),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one input transfer; called and returns right after a falling edge
	task automatic send_item(logic [1:0] act, logic [3:0] ti, logic [4:0] x, logic [4:0] y,
			logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		templ_index <= ti;
		pix_x <= x;
		pix_y <= y;
		chan0 <= c0;
		chan1 <= c1;
		chan2 <= c2;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		sb.note_input(act, ti, x, y, c0, c1, c2);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_random_pixel(logic [1:0] act, logic [3:0] ti, logic [4:0] x,
			logic [4:0] y);
		send_item(act, ti, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic classify();
		send_item(ACT_CLASSIFY, 4'($urandom), 5'($urandom), 5'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// drop valid and wait until every result is back, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// write all five registers on consecutive cycles, block is idle here
	task automatic set_regs(logic [5:0] tw, logic [5:0] th, logic [5:0] pw, logic [5:0] ph,
			logic [5:0] nt);
		logic [5:0] vals [5];
		logic [2:0] idx [5];
		vals = '{tw, th, pw, ph, nt};
		idx = '{CFG_TW, CFG_TH, CFG_PW, CFG_PH, CFG_NT};
		drain();
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			sb.write_reg(idx[i], vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// output side: random stalls, results checked at the rising edge
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(class_id, best_score, size_error);
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
				out_ready <= (stall == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCH_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int tw, th, pw, ph, nt, r, n;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every pixel that a classify below can read: 4x4 corner of each template
		// plus its whole first row, first column of template 0, 10x10 patch corner
		// plus first patch row and column
		no_gaps = 1'b1;
		for (int t = 0; t < NUM_TEMPL; t++)
			for (int y = 0; y < 4; y++)
				for (int x = 0; x < ((y == 0) ? TEMPL_DIM : 4); x++)
					send_random_pixel(ACT_TPIX, 4'(t), 5'(x), 5'(y));
		for (int y = 4; y < TEMPL_DIM; y++)
			send_random_pixel(ACT_TPIX, 4'd0, 5'd0, 5'(y));
		for (int y = 0; y < 10; y++)
			for (int x = 0; x < 10; x++)
				send_random_pixel(ACT_PPIX, 4'd0, 5'(x), 5'(y));
		for (int x = 10; x < PATCH_DIM; x++)
			send_random_pixel(ACT_PPIX, 4'd0, 5'(x), 5'd0);
		for (int y = 10; y < PATCH_DIM; y++)
			send_random_pixel(ACT_PPIX, 4'd0, 5'd0, 5'(y));
		no_gaps = 1'b0;

		// directed: extremes of fields and registers, special cases
		send_item(ACT_TPIX, 4'd0, 5'd0, 5'd0, 8'd0, 8'd0, 8'd0);
		send_item(ACT_PPIX, 4'd0, 5'd31, 5'd31, 8'hff, 8'hff, 8'hff);
		send_item(ACT_PPIX, 4'd0, 5'd0, 5'd0, 8'hff, 8'hff, 8'hff);
		send_item(ACT_TPIX, 4'd15, 5'd3, 5'd3, 8'h55, 8'haa, 8'h5a);   // template index unused
		send_item(ACT_TPIX, 4'd2, 5'd20, 5'd1, 8'h11, 8'h22, 8'h33);   // column past template
		send_item(ACT_TPIX, 4'd2, 5'd1, 5'd31, 8'h11, 8'h22, 8'h33);   // row past template
		send_item(ACT_UNUSED, 4'hf, 5'h1f, 5'h1f, 8'hff, 8'hff, 8'hff);
		send_item(ACT_TPIX, 4'd14, 5'd15, 5'd15, 8'hff, 8'h00, 8'hff);
		set_regs(6'd1, 6'd1, 6'd10, 6'd10, 6'd15);
		classify();
		set_regs(6'd4, 6'd4, 6'd10, 6'd10, 6'd15);
		classify();
		set_regs(6'd2, 6'd3, 6'd10, 6'd10, 6'd15);
		classify();
		set_regs(6'd5, 6'd2, 6'd4, 6'd8, 6'd3);        // template wider than patch
		classify();
		set_regs(6'd2, 6'd9, 6'd8, 6'd4, 6'd3);        // template taller than patch
		classify();
		set_regs(6'd0, 6'd31, 6'd0, 6'd63, 6'd0);      // saturation of every register
		classify();
		set_regs(6'd31, 6'd0, 6'd63, 6'd0, 6'd15);
		classify();
		set_regs(6'd3, 6'd3, 6'd3, 6'd3, 6'd2);        // template equal to patch
		classify();
		classify();

		// random phases: small sizes so every read stays inside the filled region
		for (int ph_i = 0; ph_i < 17; ph_i++) begin
			tw = $urandom_range(1, 4);
			th = $urandom_range(1, 4);
			pw = $urandom_range(1, 10);
			ph = $urandom_range(1, 10);
			nt = $urandom_range(1, 15);
			r = $urandom_range(0, 9);
			if (r == 0) tw = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
			if (r == 1) nt = 0;
			if (r == 2) pw = 0;
			if (r == 3) begin
				// tall patch only one column wide
				ph = $urandom_range(33, 63);
				pw = 1;
			end
			set_regs(6'(tw), 6'(th), 6'(pw), 6'(ph), 6'(nt));
			no_gaps = ($urandom_range(0, 5) == 0);
			n = $urandom_range(20, 32);
			for (int k = 0; k < n; k++) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					send_random_pixel(ACT_TPIX, 4'($urandom_range(0, nt < 1 ? 0 : nt - 1)),
						5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)));
				else if (r < 72)
					send_random_pixel(ACT_PPIX, 4'($urandom),
						5'($urandom_range(0, 9)), 5'($urandom_range(0, 9)));
				else if (r < 84)
					classify();
				else if (r < 87) begin
					// hold the sender until every pending result is back
					drain();
					classify();
				end else
					send_random_pixel(2'($urandom), 4'($urandom), 5'($urandom), 5'($urandom));
			end
			classify();
			no_gaps = 1'b0;
		end

		drain();
		repeat (20) @(negedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d expected results never arrived", sb.pending.size());
			sb.errors++;
		end
		$display("covered %0d input transfers, %0d classify requests, %0d results checked",
			sent, sb.classifies, sb.results_seen);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
